@@ rtl/wlm_pkg.sv @@
// Package for the wildcard line matcher.
// Holds shared constants, register indexes and the cell control type.
// No dependencies.
package wlm_pkg;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int LEN_W      = 6;
    localparam int NUM_WORDS  = 4;
    localparam int BYTES_W    = NUM_WORDS * CFG_DATA_W;

    localparam logic [7:0] BYTE_CR   = 8'd13;
    localparam logic [7:0] BYTE_LF   = 8'd10;
    localparam logic [7:0] GLOB_STAR = 8'h2A;
    localparam logic [7:0] GLOB_ONE  = 8'h3F;

    localparam logic [2:0] REG_LENGTH = 3'd0;
    localparam logic [2:0] REG_WORD0  = 3'd1;
    localparam logic [2:0] REG_WORD1  = 3'd2;
    localparam logic [2:0] REG_WORD2  = 3'd3;
    localparam logic [2:0] REG_WORD3  = 3'd4;

    typedef struct packed {
        logic step;
        logic line_end;
    } cell_ctl_t;

endpackage

@@ rtl/wlm_if.sv @@
// Handshake interfaces for the wildcard line matcher channels.
// Text item channel and result item channel; no package dependencies.
interface wlm_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_line;

    modport source (output valid, output text_byte, output end_of_line, input ready);
    modport sink   (input valid, input text_byte, input end_of_line, output ready);
endinterface

interface wlm_result_if;
    logic valid;
    logic ready;
    logic line_matches;

    modport source (output valid, output line_matches, input ready);
    modport sink   (input valid, input line_matches, output ready);
endinterface

@@ rtl/wildcard_line_matcher_core.sv @@
// Top level of the wildcard line matcher: cell chain, line-end stage, output register.
// Depends on wlm_pkg, wlm_if, wlm_cfg_regs and wlm_cell.
//
//   channel     dir  role    payload
//   text_in     in   sink    text_byte[7:0], end_of_line
//   result_out  out  source  line_matches
//   apb         in   slave   register writes and reads, 64-bit data
//
// One text item per cycle while text_in.ready is high; the cell chain updates all positions in that cycle.
// After a line's last byte, its final vector is latched in the cells and the
// line-end stage is set; its '*' closure then goes into the output register.
// Reset leaves only position zero active and the output empty.
// A stalled result holds the line-end stage; text items stop until the
// line-end stage moves into the output register.
module wildcard_line_matcher_core
#(
    parameter int PATTERN_MAX = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    wlm_text_if.sink                        text_in,
    wlm_result_if.source                    result_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wlm_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [wlm_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [wlm_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import wlm_pkg::*;

    localparam int LW = $clog2(PATTERN_MAX + 1);

    logic [LEN_W-1:0]       pattern_length;
    logic [BYTES_W-1:0]     pattern_bytes;
    logic [LW-1:0]          len_used;
    cell_ctl_t              ctl;
    logic                   accept;
    logic                   skip_byte;
    logic                   pend_reg;
    logic                   pend_next;
    logic                   pend_go;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_match_reg;
    logic                   out_match_next;
    logic [PATTERN_MAX:0]   star_c;
    logic [PATTERN_MAX:0]   adv_c;
    logic [PATTERN_MAX:0]   fin_c;
    logic [PATTERN_MAX:0]   fin_cl;

    wlm_cfg_regs u_cfg
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .pattern_length (pattern_length),
        .pattern_bytes  (pattern_bytes)
    );

    assign len_used = (pattern_length > LEN_W'(PATTERN_MAX)) ? LW'(PATTERN_MAX)
                                                              : LW'(pattern_length);

    assign accept       = text_in.valid & text_in.ready;
    assign skip_byte    = (text_in.text_byte == BYTE_CR) || (text_in.text_byte == BYTE_LF);
    assign ctl.step     = accept & ~skip_byte;
    assign ctl.line_end = accept & text_in.end_of_line;

    assign star_c[0] = 1'b0;
    assign adv_c[0]  = 1'b0;
    assign fin_c[0]  = 1'b0;

    for (genvar i = 0; i <= PATTERN_MAX; i++)
    begin : g_cell
        logic [7:0] pat_byte;
        logic       en;

        if (i < PATTERN_MAX)
        begin : g_byte
            assign pat_byte = pattern_bytes[8*i +: 8];
        end
        else
        begin : g_tail
            assign pat_byte = 8'h00;
        end

        assign en = (LW'(i) < len_used);

        if (i < PATTERN_MAX)
        begin : g_mid
            wlm_cell #(.IS_HEAD(i == 0)) u_cell
            (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctl          (ctl),
                .pat_byte     (pat_byte),
                .en           (en),
                .text_byte    (text_in.text_byte),
                .star_in      (star_c[i]),
                .star_out     (star_c[i+1]),
                .adv_in       (adv_c[i]),
                .adv_out      (adv_c[i+1]),
                .fin_star_in  (fin_c[i]),
                .fin_star_out (fin_c[i+1]),
                .fin_cl       (fin_cl[i])
            );
        end
        else
        begin : g_last
            wlm_cell #(.IS_HEAD(i == 0)) u_cell
            (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctl          (ctl),
                .pat_byte     (pat_byte),
                .en           (en),
                .text_byte    (text_in.text_byte),
                .star_in      (star_c[i]),
                .star_out     (),
                .adv_in       (adv_c[i]),
                .adv_out      (),
                .fin_star_in  (fin_c[i]),
                .fin_star_out (),
                .fin_cl       (fin_cl[i])
            );
        end
    end

    // line-end stage feeds the output register
    assign pend_go       = pend_reg & (~out_valid_reg | result_out.ready);
    assign text_in.ready = ~pend_reg | pend_go;

    always_comb
    begin
        pend_next = pend_reg;
        if (pend_go)
        begin
            pend_next = 1'b0;
        end
        if (ctl.line_end)
        begin
            pend_next = 1'b1;
        end

        out_valid_next = out_valid_reg;
        out_match_next = out_match_reg;
        if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pend_go)
        begin
            out_valid_next = 1'b1;
            out_match_next = fin_cl[len_used];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_match_reg <= out_match_next;
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.line_matches = out_match_reg;

endmodule

@@ rtl/wlm_cfg_regs.sv @@
// APB-style configuration registers for the wildcard line matcher.
// Holds pattern length and pattern bytes; uses wlm_pkg.
module wlm_cfg_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wlm_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [wlm_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [wlm_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready,
    output logic [wlm_pkg::LEN_W-1:0]           pattern_length,
    output logic [wlm_pkg::BYTES_W-1:0]         pattern_bytes
);
    import wlm_pkg::*;

    logic [LEN_W-1:0]      length_reg;
    logic [CFG_DATA_W-1:0] word_reg [NUM_WORDS];
    logic [2:0]            reg_index;
    logic                  wr_en;

    assign reg_index = paddr[CFG_ADDR_W-1:3];
    assign wr_en     = psel & penable & pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
            for (int w = 0; w < NUM_WORDS; w++)
            begin
                word_reg[w] <= '0;
            end
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_LENGTH: length_reg  <= pwdata[LEN_W-1:0];
                REG_WORD0:  word_reg[0] <= pwdata;
                REG_WORD1:  word_reg[1] <= pwdata;
                REG_WORD2:  word_reg[2] <= pwdata;
                REG_WORD3:  word_reg[3] <= pwdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_LENGTH: prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, length_reg};
            REG_WORD0:  prdata = word_reg[0];
            REG_WORD1:  prdata = word_reg[1];
            REG_WORD2:  prdata = word_reg[2];
            REG_WORD3:  prdata = word_reg[3];
            default:    prdata = '0;
        endcase
    end

    assign pattern_length = length_reg;

    for (genvar w = 0; w < NUM_WORDS; w++)
    begin : g_words
        assign pattern_bytes[w*CFG_DATA_W +: CFG_DATA_W] = word_reg[w];
    end

endmodule

@@ rtl/wlm_cell.sv @@
// One pattern position of the matcher chain.
// Holds the active bit and the line-end snapshot bit; uses wlm_pkg.
module wlm_cell
#(
    parameter bit IS_HEAD = 1'b0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  wlm_pkg::cell_ctl_t ctl,
    input  logic [7:0]         pat_byte,
    input  logic               en,
    input  logic [7:0]         text_byte,
    input  logic               star_in,
    output logic               star_out,
    input  logic               adv_in,
    output logic               adv_out,
    input  logic               fin_star_in,
    output logic               fin_star_out,
    output logic               fin_cl
);
    import wlm_pkg::*;

    logic act_reg;
    logic act_next;
    logic fin_reg;
    logic fin_next;
    logic cl;
    logic is_star;
    logic hit;
    logic nxt;

    assign is_star = (pat_byte == GLOB_STAR);
    assign hit     = (pat_byte == GLOB_ONE) || (pat_byte == text_byte);

    // closure across '*' from the left neighbor, then advance by one byte
    assign cl       = act_reg | star_in;
    assign star_out = cl & en & is_star;
    assign adv_out  = cl & en & ~is_star & hit;
    assign nxt      = star_out | adv_in;

    assign fin_cl       = fin_reg | fin_star_in;
    assign fin_star_out = fin_cl & en & is_star;

    always_comb
    begin
        if (ctl.line_end)
        begin
            act_next = IS_HEAD;
        end
        else if (ctl.step)
        begin
            act_next = nxt;
        end
        else
        begin
            act_next = act_reg;
        end
        if (ctl.line_end)
        begin
            fin_next = ctl.step ? nxt : act_reg;
        end
        else
        begin
            fin_next = fin_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= IS_HEAD;
            fin_reg <= 1'b0;
        end
        else
        begin
            act_reg <= act_next;
            fin_reg <= fin_next;
        end
    end

endmodule

@@ test/tb_top.sv @@
// Testbench for wildcard_line_matcher_core: streams text lines, checks each line verdict
// against a glob predictor that runs in a small class. Uses wlm_pkg and the interfaces
// in wlm_if; pattern registers are written over the APB port between phases.
`timescale 1ns / 100ps

module tb_top;
    import wlm_pkg::*;

    localparam int          PATTERN_MAX   = 32;
    localparam int          RANDOM_ITEMS  = 1830;
    localparam int          HOLD_AFTER    = 700;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          DRAIN_CYCLES  = 4;
    localparam logic [2:0]  REG_SPARE     = 3'd5;
    localparam logic [2:0]  REG_SLOT_LAST = 3'd7;
    localparam logic [7:0]  CHAR_A        = 8'h61;

    class glob_line_predictor;
        logic [5:0]  length_reg;
        logic [63:0] words [4];
        logic [32:0] active;
        bit          pending_verdicts [$];
        int          failures;
        int          verdicts_checked;

        function new();
            length_reg = '0;
            foreach (words[k]) words[k] = '0;
            active = 33'd1;
            failures = 0;
            verdicts_checked = 0;
        endfunction

        function int used_length();
            return (length_reg > PATTERN_MAX) ? PATTERN_MAX : int'(length_reg);
        endfunction

        function logic [7:0] pattern_byte(int i);
            return words[i / 8][(i % 8) * 8 +: 8];
        endfunction

        function int outstanding();
            return pending_verdicts.size();
        endfunction

        function logic [32:0] close_stars(logic [32:0] v);
            int i;
            logic [32:0] r;
            r = v;
            for (i = 0; i < used_length(); i++)
                if (r[i] && pattern_byte(i) == GLOB_STAR)
                    r[i + 1] = 1'b1;
            return r;
        endfunction

        function void set_register(logic [2:0] idx, logic [63:0] value);
            case (idx)
                REG_LENGTH: length_reg = value[5:0];
                REG_WORD0:  words[0] = value;
                REG_WORD1:  words[1] = value;
                REG_WORD2:  words[2] = value;
                REG_WORD3:  words[3] = value;
                default: ;
            endcase
        endfunction

        function void note_text(logic [7:0] b, bit eol);
            int i;
            int n;
            logic [32:0] v;
            logic [32:0] nxt;
            n = used_length();
            if (b != BYTE_CR && b != BYTE_LF)
            begin
                v = close_stars(active);
                nxt = '0;
                for (i = 0; i < n; i++)
                begin
                    if (v[i])
                    begin
                        if (pattern_byte(i) == GLOB_STAR)
                            nxt[i] = 1'b1;
                        else if (pattern_byte(i) == GLOB_ONE || pattern_byte(i) == b)
                            nxt[i + 1] = 1'b1;
                    end
                end
                active = nxt;
            end
            if (eol)
            begin
                v = close_stars(active);
                pending_verdicts.push_back(v[n]);
                active = 33'd1;
            end
        endfunction

        function void check_verdict(bit got);
            bit want;
            if (pending_verdicts.size() == 0)
            begin
                failures++;
                $display("%0t: line_matches expected none, got %0b", $time, got);
                return;
            end
            want = pending_verdicts.pop_front();
            verdicts_checked++;
            if (want != got)
            begin
                failures++;
                $display("%0t: line_matches expected %0b, got %0b", $time, want, got);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    wlm_text_if   text_ch();
    wlm_result_if result_ch();

    glob_line_predictor sb = new();

    int         items_sent = 0;
    int         lines_sent = 0;
    int         settings_count = 0;
    int         stall_left = 0;
    bit         steady = 1'b0;
    bit         results_held = 1'b0;
    logic [7:0] line_bytes [$];

    wildcard_line_matcher_core #(
        .PATTERN_MAX (PATTERN_MAX)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_ch),
        .result_out (result_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("tb_top failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_filler();
        logic [7:0] b;
        if ($urandom_range(0, 1))
            return CHAR_A + 8'($urandom_range(0, 1));
        b = 8'($urandom_range(0, 255));
        if (b == BYTE_CR || b == BYTE_LF)
            b = ~b;
        return b;
    endfunction

    function automatic logic [7:0] pick_pattern_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return CHAR_A + 8'($urandom_range(0, 1));
        if (r < 60)
            return GLOB_STAR;
        if (r < 75)
            return GLOB_ONE;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [63:0] pick_word();
        int r;
        logic [63:0] w;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 10)
            return '1;
        for (int k = 0; k < 8; k++)
            w[k * 8 +: 8] = pick_pattern_byte();
        return w;
    endfunction

    // drop the text valid at the next falling edge
    task automatic idle_text();
        @(negedge clk);
        text_ch.valid = 1'b0;
    endtask

    task automatic send_text(logic [7:0] b, bit eol);
        int gap;
        gap = steady ? 0 : pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            text_ch.valid = 1'b0;
        end
        @(negedge clk);
        text_ch.valid       = 1'b1;
        text_ch.text_byte   = b;
        text_ch.end_of_line = eol;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        sb.note_text(b, eol);
        items_sent++;
        if (eol)
            lines_sent++;
    endtask

    task automatic write_register(logic [2:0] idx, logic [63:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_register(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // wait until every verdict is in and the pipeline has drained
    task automatic settle();
        idle_text();
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_random_pattern(bit all_words);
        int r;
        logic [5:0] len;
        r = $urandom_range(0, 99);
        if (r < 70)
            len = 6'($urandom_range(0, 10));
        else if (r < 85)
            len = 6'($urandom_range(11, 31));
        else if (r < 95)
            len = 6'd32;
        else
            len = 6'($urandom_range(33, 63));
        write_register(REG_LENGTH, {58'd0, len});
        for (int k = 0; k < NUM_WORDS; k++)
            if (all_words || $urandom_range(0, 1))
                write_register(3'(REG_WORD0 + k), pick_word());
        if ($urandom_range(0, 9) == 0)
            write_register(3'($urandom_range(REG_SPARE, REG_SLOT_LAST)), {$urandom, $urandom});
    endtask

    function automatic void build_line(bit well_formed);
        int k;
        logic [7:0] p;
        line_bytes.delete();
        if (well_formed)
        begin
            for (int i = 0; i < sb.used_length(); i++)
            begin
                p = sb.pattern_byte(i);
                if (p == GLOB_STAR)
                    repeat ($urandom_range(0, 3)) line_bytes.push_back(pick_filler());
                else if (p == GLOB_ONE)
                    line_bytes.push_back(pick_filler());
                else
                    line_bytes.push_back(p);
            end
            if ($urandom_range(0, 99) < 30 && line_bytes.size() > 0)
            begin
                k = $urandom_range(0, line_bytes.size() - 1);
                if ($urandom_range(0, 1))
                    line_bytes[k] = pick_filler();
                else
                    line_bytes.delete(k);
            end
        end
        else
        begin
            repeat ($urandom_range(0, 12)) line_bytes.push_back(pick_filler());
        end
        if ($urandom_range(0, 9) == 0)
        begin
            k = $urandom_range(0, line_bytes.size());
            line_bytes.insert(k, $urandom_range(0, 1) ? BYTE_CR : BYTE_LF);
        end
    endfunction

    task automatic send_line();
        bit skip_end;
        skip_end = (line_bytes.size() == 0) || ($urandom_range(0, 99) < 15);
        foreach (line_bytes[i])
            send_text(line_bytes[i], !skip_end && i == line_bytes.size() - 1);
        if (skip_end)
            send_text($urandom_range(0, 1) ? BYTE_CR : BYTE_LF, 1'b1);
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (results_held)
                result_ch.ready = 1'b0;
            else if (steady)
                result_ch.ready = 1'b1;
            else if (stall_left > 0)
            begin
                result_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                result_ch.ready = 1'b1;
                if ($urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_verdict(result_ch.line_matches);
    end

    // hold off the result side while text keeps coming, so the input backs up
    initial
    begin
        wait (items_sent >= HOLD_AFTER);
        @(posedge clk);
        results_held = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        results_held = 1'b0;
    end

    initial
    begin
        int goal;
        int phase_goal;
        int phase_no;

        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        text_ch.valid       = 1'b0;
        text_ch.text_byte   = '0;
        text_ch.end_of_line = 1'b0;
        result_ch.ready     = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty pattern from reset: only lines of CR/LF alone match
        send_text(BYTE_CR, 1'b1);
        send_text(8'h00, 1'b1);
        send_text(BYTE_LF, 1'b0);
        send_text(8'hFF, 1'b1);
        settle();

        // oversized length clamps to the full 32 bytes; spare index is ignored
        write_register(REG_SPARE, '1);
        write_register(REG_LENGTH, 64'd63);
        write_register(REG_WORD0, 64'h2A2A_2A2A_2A2A_2A3F);
        write_register(REG_WORD1, 64'h2A2A_2A2A_2A2A_2A2A);
        write_register(REG_WORD2, 64'h2A2A_2A2A_2A2A_2A2A);
        write_register(REG_WORD3, 64'hFF2A_2A2A_2A2A_2A2A);
        settings_count++;
        send_text(BYTE_CR, 1'b1);
        send_text(8'hFF, 1'b1);
        send_text(8'h58, 1'b0);
        send_text(8'hFF, 1'b1);
        settle();

        // "a?*b": literal, single-byte and run wildcards, CR on the last item
        write_register(REG_LENGTH, 64'd4);
        write_register(REG_WORD0, 64'h0000_0000_622A_3F61);
        settings_count++;
        send_text(8'h61, 1'b0);
        send_text(8'h78, 1'b0);
        send_text(8'h62, 1'b1);
        send_text(8'h61, 1'b0);
        send_text(8'h78, 1'b0);
        send_text(8'h79, 1'b0);
        send_text(8'h7A, 1'b0);
        send_text(8'h62, 1'b1);
        send_text(8'h61, 1'b0);
        send_text(8'h62, 1'b1);
        send_text(8'h61, 1'b0);
        send_text(8'h78, 1'b0);
        send_text(8'h62, 1'b0);
        send_text(BYTE_CR, 1'b1);

        goal = items_sent + RANDOM_ITEMS;
        phase_no = 0;
        while (items_sent < goal)
        begin
            settle();
            if (phase_no == 1)
            begin
                write_register(REG_LENGTH, 64'd32);
                for (int k = 0; k < NUM_WORDS; k++)
                    write_register(3'(REG_WORD0 + k), '1);
            end
            else
            begin
                program_random_pattern(phase_no == 0);
            end
            settings_count++;
            steady = ($urandom_range(0, 4) == 0);
            phase_goal = items_sent + $urandom_range(40, 140);
            while (items_sent < phase_goal && items_sent < goal)
            begin
                build_line($urandom_range(0, 99) < 70);
                send_line();
            end
            phase_no++;
        end

        idle_text();
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        $display("sent %0d text items in %0d lines across %0d pattern settings",
                 items_sent, lines_sent, settings_count);
        $display("checked %0d line verdicts, %0d mismatches", sb.verdicts_checked,
                 sb.failures);
        if (sb.failures == 0 && sb.outstanding() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
